/* sv/gdsavg_pkg.sv */
package gdsavg_pkg;

   // Limits of the source frame and of the reduced image
   localparam int SRC_MAX_DIM = 1024;
   localparam int OUT_MAX_DIM = 128;

   // Field and register widths
   localparam int PIX_W     = 8;
   localparam int DIM_W     = 11;
   localparam int OUT_DIM_W = 8;
   localparam int POS_W     = 10;
   localparam int OUT_POS_W = 7;
   localparam int CSR_ADDR_W = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_ADDR_W-1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_OUT_COLS   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_OUT_ROWS   = 2'd3;

   // Register values after reset
   localparam logic [DIM_W-1:0]     RST_SRC_WIDTH  = 11'd80;
   localparam logic [DIM_W-1:0]     RST_SRC_HEIGHT = 11'd60;
   localparam logic [OUT_DIM_W-1:0] RST_OUT_COLS   = 8'd80;
   localparam logic [OUT_DIM_W-1:0] RST_OUT_ROWS   = 8'd60;

   // Division operand widths: index (7 bit) times source size (11 bit)
   localparam int PROD_W = 17;
   localparam int QUO_W  = 10;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [OUT_POS_W-1:0] out_x;
      logic [OUT_POS_W-1:0] out_y;
      logic [PIX_W-1:0]     value;
      logic                 last;
   } rsp_type;

   // Source size clamped to 1..SRC_MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_src(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (v > DIM_W'(SRC_MAX_DIM)) begin
         return DIM_W'(SRC_MAX_DIM);
      end
      return v;
   endfunction

   // Output size clamped to 1..OUT_MAX_DIM
   function automatic logic [OUT_DIM_W-1:0] clamp_out(input logic [OUT_DIM_W-1:0] v);
      if (v == '0) begin
         return OUT_DIM_W'(1);
      end else if (v > OUT_DIM_W'(OUT_MAX_DIM)) begin
         return OUT_DIM_W'(OUT_MAX_DIM);
      end
      return v;
   endfunction

endpackage

/* sv/gdsavg_div.sv */
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in QUO_W bits, so the upper dividend bits seed the partial remainder.
module gdsavg_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [gdsavg_pkg::PROD_W-1:0]    dividend,
   input  logic [gdsavg_pkg::OUT_DIM_W-1:0] divisor,
   output logic                             done,
   output logic [gdsavg_pkg::QUO_W-1:0]     quotient
);

   logic [gdsavg_pkg::OUT_DIM_W-1:0] rem_ff, rem_in;
   logic [gdsavg_pkg::OUT_DIM_W-1:0] div_ff, div_in;
   logic [gdsavg_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [3:0]                       cnt_ff, cnt_in;
   logic                             done_ff, done_in;
   logic [gdsavg_pkg::OUT_DIM_W:0]   trial;

   assign trial = {rem_ff, quo_ff[gdsavg_pkg::QUO_W-1]};

   // Next state of the shift and subtract loop
   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = gdsavg_pkg::OUT_DIM_W'(dividend[gdsavg_pkg::PROD_W-1:gdsavg_pkg::QUO_W]);
         quo_in = dividend[gdsavg_pkg::QUO_W-1:0];
         div_in = divisor;
         cnt_in = 4'(gdsavg_pkg::QUO_W);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = gdsavg_pkg::OUT_DIM_W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[gdsavg_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[gdsavg_pkg::OUT_DIM_W-1:0];
            quo_in = {quo_ff[gdsavg_pkg::QUO_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 4'd1;
         done_in = (cnt_ff == 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* sv/grayscale_downscale_2x2_average.sv */
// 2x2 box-average downscaler for an 8-bit grayscale pixel stream.
// Input channel req_*: one source pixel per transfer in raster order;
// frame_start marks source pixel (0,0) and restarts all position counters.
// Result channel rsp_*: output pixels (out_x, out_y, value), each the
// truncated mean of a 2x2 source block; last marks the final result caused
// by one source pixel. A pixel causes zero to four results.
// Configuration: csr_we/csr_addr/csr_wdata write src_width, src_height,
// out_cols and out_rows (indexes 0..3); write only while the block is idle.
// One pixel at a time: the block takes it, tests each candidate output row
// and then column (up to two of each) with a start state and a wait on a
// shared serial divider computing index*size/count, closes each search that
// ends without a miss, queues each result and then writes back.
// The previous source line
// sits in a 1024 x 8 single-port line RAM, read when a pixel is taken and
// written back once its results are queued, so accesses never overlap.
// After reset the line RAM is cleared, all 1024 entries, with req_stall high.
// Results leave through an output register; while the receiver stalls the
// block keeps working until it has a further result to queue, and it may
// take the next pixel whilst the last result still waits.
module grayscale_downscale_2x2_average (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gdsavg_pkg::req_type               req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gdsavg_pkg::rsp_type               rsp_data,
   input  logic                              csr_we,
   input  logic [gdsavg_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [gdsavg_pkg::DIM_W-1:0]      csr_wdata
);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_ROW      = 3'd2;
   localparam logic [2:0] ST_ROW_WAIT = 3'd3;
   localparam logic [2:0] ST_COL      = 3'd4;
   localparam logic [2:0] ST_COL_WAIT = 3'd5;
   localparam logic [2:0] ST_EMIT     = 3'd6;
   localparam logic [2:0] ST_UPDATE   = 3'd7;

   localparam int PW = gdsavg_pkg::PIX_W;
   localparam int DW = gdsavg_pkg::DIM_W;
   localparam int OW = gdsavg_pkg::OUT_DIM_W;
   localparam int SW = gdsavg_pkg::POS_W;

   // Line RAM
   logic [PW-1:0] line_mem [gdsavg_pkg::SRC_MAX_DIM];
   logic [PW-1:0] mem_q_ff;
   logic          mem_we, mem_re;
   logic [SW-1:0] mem_waddr, mem_raddr;
   logic [PW-1:0] mem_wdata;

   // Control and position state
   logic [2:0]    state_ff, state_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic [DW-1:0] src_width_ff, src_width_in, src_height_ff, src_height_in;
   logic [OW-1:0] out_cols_ff, out_cols_in, out_rows_ff, out_rows_in;
   logic [SW-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [OW-1:0] nocol_ff, nocol_in, norow_ff, norow_in;
   logic [1:0]    k_ff, k_in;
   logic [1:0]    nrows_ff, nrows_in, ncols_ff, ncols_in;
   logic [1:0]    row_up_ff, row_up_in, col_lf_ff, col_lf_in;
   logic          ei_ff, ei_in, ej_ff, ej_in;
   logic [PW-1:0] cur_ff, cur_in, left_ff, left_in, diag_ff, diag_in;
   logic          rsp_valid_ff, rsp_valid_in;
   gdsavg_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Derived values
   logic [DW-1:0] w, h;
   logic [OW-1:0] nc, nr;
   logic          accept, out_free;
   logic [OW:0]   y_cand, x_cand;
   logic          row_go, col_go;
   logic          div_start, div_done;
   logic [6:0]    mul_a;
   logic [DW-1:0] mul_b;
   logic [17:0]   prod;
   logic [OW-1:0] div_den;
   logic [gdsavg_pkg::QUO_W-1:0] div_q;
   logic [DW-1:0] edge_s, edge_far;
   logic          row_hit, col_hit;
   logic          up, lf, last_col, last_row;
   logic [PW-1:0] above, p00, p01, p10;
   logic [PW+1:0] sum;
   logic          c_last, r_last;

   assign w  = gdsavg_pkg::clamp_src(src_width_ff);
   assign h  = gdsavg_pkg::clamp_src(src_height_ff);
   assign nc = gdsavg_pkg::clamp_out(out_cols_ff);
   assign nr = gdsavg_pkg::clamp_out(out_rows_ff);

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign above     = mem_q_ff;

   // Candidate output row and column for this pixel
   assign y_cand = (OW+1)'(norow_ff) + (OW+1)'(k_ff);
   assign x_cand = (OW+1)'(nocol_ff) + (OW+1)'(k_ff);
   assign row_go = (k_ff != 2'd2) && (y_cand < (OW+1)'(nr));
   assign col_go = (k_ff != 2'd2) && (x_cand < (OW+1)'(nc));

   // Block origin index*size/count through the serial divider
   assign mul_a     = (state_ff == ST_ROW) ? y_cand[6:0] : x_cand[6:0];
   assign mul_b     = (state_ff == ST_ROW) ? h : w;
   assign div_den   = (state_ff == ST_ROW) ? nr : nc;
   assign prod      = {11'd0, mul_a} * {7'd0, mul_b};
   assign div_start = ((state_ff == ST_ROW) && row_go) || ((state_ff == ST_COL) && col_go);

   gdsavg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod[gdsavg_pkg::PROD_W-1:0]),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // Far edge of the block, clamped to the last line or column
   always_comb begin
      edge_s = DW'(div_q);
      if (state_ff == ST_ROW_WAIT) begin
         edge_far = ((edge_s + DW'(1)) < h) ? edge_s + DW'(1) : edge_s;
      end else begin
         edge_far = ((edge_s + DW'(1)) < w) ? edge_s + DW'(1) : edge_s;
      end
   end
   assign row_hit = (edge_far == DW'(src_row_ff));
   assign col_hit = (edge_far == DW'(src_col_ff));

   // Average of the 2x2 block for the current result
   assign up  = row_up_ff[ei_ff];
   assign lf  = col_lf_ff[ej_ff];
   assign p00 = up ? (lf ? diag_ff : above) : (lf ? left_ff : cur_ff);
   assign p01 = up ? above : cur_ff;
   assign p10 = lf ? left_ff : cur_ff;
   assign sum = (PW+2)'(p00) + (PW+2)'(p01) + (PW+2)'(p10) + (PW+2)'(cur_ff);
   assign last_col = ((2'(ej_ff) + 2'd1) == ncols_ff);
   assign last_row = ((2'(ei_ff) + 2'd1) == nrows_ff);

   assign c_last = (DW'(src_col_ff) >= (w - DW'(1)));
   assign r_last = (DW'(src_row_ff) >= (h - DW'(1)));

   // Line RAM ports
   assign mem_we    = (state_ff == ST_CLEAR) || (state_ff == ST_UPDATE);
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_ff : src_col_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : cur_ff;
   assign mem_re    = accept;
   assign mem_raddr = req_data.frame_start ? '0 : src_col_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= line_mem[mem_raddr];
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      out_cols_in   = out_cols_ff;
      out_rows_in   = out_rows_ff;
      src_col_in    = src_col_ff;
      src_row_in    = src_row_ff;
      nocol_in      = nocol_ff;
      norow_in      = norow_ff;
      k_in          = k_ff;
      nrows_in      = nrows_ff;
      ncols_in      = ncols_ff;
      row_up_in     = row_up_ff;
      col_lf_in     = col_lf_ff;
      ei_in         = ei_ff;
      ej_in         = ej_ff;
      cur_in        = cur_ff;
      left_in       = left_ff;
      diag_in       = diag_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      // configuration writes
      if (csr_we) begin
         case (csr_addr)
            gdsavg_pkg::REG_SRC_WIDTH:  src_width_in  = csr_wdata;
            gdsavg_pkg::REG_SRC_HEIGHT: src_height_in = csr_wdata;
            gdsavg_pkg::REG_OUT_COLS:   out_cols_in   = csr_wdata[OW-1:0];
            gdsavg_pkg::REG_OUT_ROWS:   out_rows_in   = csr_wdata[OW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SW'(1);
            if (clr_ff == SW'(gdsavg_pkg::SRC_MAX_DIM - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cur_in = req_data.pixel;
               if (req_data.frame_start) begin
                  src_col_in = '0;
                  src_row_in = '0;
                  nocol_in   = '0;
                  norow_in   = '0;
               end
               k_in     = '0;
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            if (row_go) begin
               state_in = ST_ROW_WAIT;
            end else begin
               nrows_in = k_ff;
               k_in     = '0;
               state_in = ST_COL;
            end
         end
         ST_ROW_WAIT: begin
            if (div_done) begin
               if (row_hit) begin
                  row_up_in[k_ff[0]] = (edge_s != DW'(src_row_ff));
                  k_in     = k_ff + 2'd1;
                  state_in = ST_ROW;
               end else begin
                  nrows_in = k_ff;
                  k_in     = '0;
                  state_in = ST_COL;
               end
            end
         end
         ST_COL: begin
            if (col_go) begin
               state_in = ST_COL_WAIT;
            end else begin
               ncols_in = k_ff;
               ei_in    = 1'b0;
               ej_in    = 1'b0;
               state_in = ((nrows_ff == '0) || (k_ff == '0)) ? ST_UPDATE : ST_EMIT;
            end
         end
         ST_COL_WAIT: begin
            if (div_done) begin
               if (col_hit) begin
                  col_lf_in[k_ff[0]] = (edge_s != DW'(src_col_ff));
                  k_in     = k_ff + 2'd1;
                  state_in = ST_COL;
               end else begin
                  ncols_in = k_ff;
                  ei_in    = 1'b0;
                  ej_in    = 1'b0;
                  state_in = ((nrows_ff == '0) || (k_ff == '0)) ? ST_UPDATE : ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            // queue one result per free slot of the output register
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_data_in.out_x = nocol_ff[6:0] + 7'(ej_ff);
               rsp_data_in.out_y = norow_ff[6:0] + 7'(ei_ff);
               rsp_data_in.value = sum[PW+1:2];
               rsp_data_in.last  = last_row && last_col;
               if (last_col) begin
                  ej_in = 1'b0;
                  if (last_row) begin
                     state_in = ST_UPDATE;
                  end else begin
                     ei_in = 1'b1;
                  end
               end else begin
                  ej_in = 1'b1;
               end
            end
         end
         ST_UPDATE: begin
            // line RAM write happens this cycle; advance the raster position
            left_in = cur_ff;
            diag_in = above;
            if (c_last) begin
               src_col_in = '0;
               nocol_in   = '0;
               if (r_last) begin
                  src_row_in = '0;
                  norow_in   = '0;
               end else begin
                  src_row_in = src_row_ff + SW'(1);
                  norow_in   = norow_ff + OW'(nrows_ff);
               end
            end else begin
               src_col_in = src_col_ff + SW'(1);
               nocol_in   = nocol_ff + OW'(ncols_ff);
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         src_width_ff  <= gdsavg_pkg::RST_SRC_WIDTH;
         src_height_ff <= gdsavg_pkg::RST_SRC_HEIGHT;
         out_cols_ff   <= gdsavg_pkg::RST_OUT_COLS;
         out_rows_ff   <= gdsavg_pkg::RST_OUT_ROWS;
         src_col_ff    <= '0;
         src_row_ff    <= '0;
         nocol_ff      <= '0;
         norow_ff      <= '0;
         k_ff          <= '0;
         nrows_ff      <= '0;
         ncols_ff      <= '0;
         ei_ff         <= 1'b0;
         ej_ff         <= 1'b0;
         left_ff       <= '0;
         diag_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         out_cols_ff   <= out_cols_in;
         out_rows_ff   <= out_rows_in;
         src_col_ff    <= src_col_in;
         src_row_ff    <= src_row_in;
         nocol_ff      <= nocol_in;
         norow_ff      <= norow_in;
         k_ff          <= k_in;
         nrows_ff      <= nrows_in;
         ncols_ff      <= ncols_in;
         ei_ff         <= ei_in;
         ej_ff         <= ej_in;
         left_ff       <= left_in;
         diag_ff       <= diag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      row_up_ff   <= row_up_in;
      col_lf_ff   <= col_lf_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
